[rtl/prc_pkg.sv]
// prc_pkg: shared types, widths and codes of the point region classifier
// no dependencies; taken in by every other file of the block
`default_nettype none

package prc_pkg;

    // default coordinate width of a point component
    localparam int COORD_WIDTH_DEF = 16;

    // fixed field widths
    localparam int TAG_W      = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int KIND_W     = 3;
    localparam int AXIS_W     = 2;
    localparam int RAD_W      = 16;

    // component differences saturate in magnitude at DIFF_CAP
    localparam int DIFF_CAP   = 262144;
    localparam int MAG_W      = 19;
    localparam int SQ_W       = 37;
    localparam int SUM_W      = 39;

    // widened radii and their squares
    localparam int OUTER_W    = RAD_W + 1;
    localparam int OUTER2_W   = 2 * OUTER_W;
    localparam int INNER2_W   = 2 * RAD_W;

    // region kinds
    localparam logic [KIND_W-1:0] KIND_ALL     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BOX     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CIRCLE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ANNULUS = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SPHERE  = 3'd4;

    // normal axis codes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_KIND     = 3'd0,
        CFG_BOX_LOW_CORNER  = 3'd1,
        CFG_BOX_HIGH_CORNER = 3'd2,
        CFG_REGION_CENTER   = 3'd3,
        CFG_NORMAL_AXIS     = 3'd4,
        CFG_OUTER_RADIUS    = 3'd5,
        CFG_INNER_RADIUS    = 3'd6,
        CFG_TOLERANCE       = 3'd7
    } cfg_index_t;

    // configuration register file
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] high;
        logic [CFG_DATA_W-1:0] center;
        logic [AXIS_W-1:0]     axis;
        logic [RAD_W-1:0]      outer;
        logic [RAD_W-1:0]      inner;
        logic [RAD_W-1:0]      tol;
    } cfg_t;

    // after the difference stage
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic [2:0][MAG_W-1:0]     mag;
        logic                      box_ok;
        logic [KIND_W-1:0]         kind;
        logic [AXIS_W-1:0]         axis;
        logic [OUTER_W-1:0]        outer_sum;
        logic                      inner_on;
        logic [RAD_W-1:0]          inner_r;
    } diff_t;

    // after the square stage
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic [2:0][SQ_W-1:0]      sq;
        logic                      box_ok;
        logic [KIND_W-1:0]         kind;
        logic [AXIS_W-1:0]         axis;
        logic [OUTER2_W-1:0]       outer2;
        logic                      inner_on;
        logic [INNER2_W-1:0]       inner2;
    } square_t;

    // after the sum stage
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic [SUM_W-1:0]          d2all;
        logic [SUM_W-1:0]          d2rad;
        logic                      box_ok;
        logic [KIND_W-1:0]         kind;
        logic [OUTER2_W-1:0]       outer2;
        logic                      inner_on;
        logic [INNER2_W-1:0]       inner2;
    } sum_t;

    // classified item
    typedef struct packed {
        logic             in_region;
        logic [TAG_W-1:0] tag;
    } result_t;

endpackage

`default_nettype wire

[rtl/prc_point_if.sv]
// prc_point_if: valid/ready channel carrying one point item
// depends on prc_pkg
`default_nettype none

interface prc_point_if
    import prc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [TAG_W-1:0]              point_tag;

    modport source (output valid, point_x, point_y, point_z, point_tag, input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_tag, output ready);
endinterface

`default_nettype wire

[rtl/prc_result_if.sv]
// prc_result_if: valid/ready channel carrying one classification item
// depends on prc_pkg
`default_nettype none

interface prc_result_if
    import prc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [TAG_W-1:0] result_tag;

    modport source (output valid, inside_res, result_tag, input ready);
    modport sink   (input valid, inside_res, result_tag, output ready);
endinterface

`default_nettype wire

[rtl/prc_diff_stage.sv]
// prc_diff_stage: first pipeline stage, center differences and box test
// depends on prc_pkg
`default_nettype none

module prc_diff_stage
    import prc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cfg_t                          cfg,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic signed [COORD_WIDTH-1:0] pz,
    input  wire logic [TAG_W-1:0]              ptag,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output diff_t                              dn
);
    localparam int EXT_W = 3 * COORD_WIDTH;
    localparam int DW    = COORD_WIDTH + 1;
    localparam int MW    = (DW > MAG_W) ? DW : MAG_W;
    localparam int BW    = COORD_WIDTH + 18;

    logic                  valid_reg;
    diff_t                 data_reg;
    diff_t                 data_next;
    logic [EXT_W-1:0]      low_ext;
    logic [EXT_W-1:0]      high_ext;
    logic [EXT_W-1:0]      center_ext;
    logic [2:0][COORD_WIDTH-1:0] pt;
    logic [2:0]            axis_ok;

    // packed fields: zero beyond the register, cut when narrower
    assign low_ext    = EXT_W'({{EXT_W{1'b0}}, cfg.low});
    assign high_ext   = EXT_W'({{EXT_W{1'b0}}, cfg.high});
    assign center_ext = EXT_W'({{EXT_W{1'b0}}, cfg.center});

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    // per axis: saturated distance to center and widened box bounds
    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic signed [COORD_WIDTH-1:0] c;
        logic signed [DW-1:0]          d;
        logic [DW-1:0]                 m;
        logic [MW-1:0]                 m_ext;
        logic signed [BW-1:0]          p_b;
        logic signed [BW-1:0]          lo_b;
        logic signed [BW-1:0]          hi_b;
        logic signed [BW-1:0]          tol_b;

        assign c     = center_ext[i*COORD_WIDTH +: COORD_WIDTH];
        assign d     = {pt[i][COORD_WIDTH-1], pt[i]} - {c[COORD_WIDTH-1], c};
        assign m     = d[DW-1] ? DW'(-d) : DW'(d);
        assign m_ext = MW'(m);
        assign data_next.mag[i] = (m_ext > MW'(DIFF_CAP)) ? MAG_W'(DIFF_CAP)
                                                           : m_ext[MAG_W-1:0];

        assign tol_b = {{(BW-RAD_W){1'b0}}, cfg.tol};
        assign p_b   = {{(BW-COORD_WIDTH){pt[i][COORD_WIDTH-1]}}, pt[i]};
        assign lo_b  = {{(BW-COORD_WIDTH){low_ext[(i+1)*COORD_WIDTH-1]}},
                        low_ext[i*COORD_WIDTH +: COORD_WIDTH]} - tol_b;
        assign hi_b  = {{(BW-COORD_WIDTH){high_ext[(i+1)*COORD_WIDTH-1]}},
                        high_ext[i*COORD_WIDTH +: COORD_WIDTH]} + tol_b;
        assign axis_ok[i] = (p_b >= lo_b) && (p_b <= hi_b);
    end

    // radii widened and narrowed by the tolerance
    assign data_next.tag       = ptag;
    assign data_next.box_ok    = &axis_ok;
    assign data_next.kind      = cfg.kind;
    assign data_next.axis      = cfg.axis;
    assign data_next.outer_sum = {1'b0, cfg.outer} + {1'b0, cfg.tol};
    assign data_next.inner_on  = cfg.inner > cfg.tol;
    assign data_next.inner_r   = cfg.inner - cfg.tol;

    // stage handshake
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;
endmodule

`default_nettype wire

[rtl/prc_square_stage.sv]
// prc_square_stage: second pipeline stage, squares of differences and radii
// depends on prc_pkg
`default_nettype none

module prc_square_stage
    import prc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_ready,
    input  wire diff_t up,
    output logic       dn_valid,
    input  wire logic  dn_ready,
    output square_t    dn
);
    logic    valid_reg;
    square_t data_reg;
    square_t data_next;

    // one multiplier per component, magnitude is at most the cap
    for (genvar i = 0; i < 3; i++) begin : g_sq
        logic [2*MAG_W-1:0] prod;
        assign prod = up.mag[i] * up.mag[i];
        assign data_next.sq[i] = prod[SQ_W-1:0];
    end

    // squared bounds
    assign data_next.outer2   = up.outer_sum * up.outer_sum;
    assign data_next.inner2   = up.inner_r * up.inner_r;
    assign data_next.tag      = up.tag;
    assign data_next.box_ok   = up.box_ok;
    assign data_next.kind     = up.kind;
    assign data_next.axis     = up.axis;
    assign data_next.inner_on = up.inner_on;

    // stage handshake
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;
endmodule

`default_nettype wire

[rtl/prc_sum_stage.sv]
// prc_sum_stage: third pipeline stage, full and radial squared distances
// depends on prc_pkg
`default_nettype none

module prc_sum_stage
    import prc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    up_valid,
    output logic         up_ready,
    input  wire square_t up,
    output logic         dn_valid,
    input  wire logic    dn_ready,
    output sum_t         dn
);
    logic             valid_reg;
    sum_t             data_reg;
    sum_t             data_next;
    logic [2:0][SUM_W-1:0] sq_ext;
    logic [2:0][SUM_W-1:0] sq_rad;

    // the component along the normal axis drops out of the radial sum;
    // an unused axis code keeps all three
    assign sq_ext[0] = SUM_W'(up.sq[0]);
    assign sq_ext[1] = SUM_W'(up.sq[1]);
    assign sq_ext[2] = SUM_W'(up.sq[2]);
    assign sq_rad[0] = (up.axis == AXIS_X) ? '0 : sq_ext[0];
    assign sq_rad[1] = (up.axis == AXIS_Y) ? '0 : sq_ext[1];
    assign sq_rad[2] = (up.axis == AXIS_Z) ? '0 : sq_ext[2];

    assign data_next.d2all    = sq_ext[0] + sq_ext[1] + sq_ext[2];
    assign data_next.d2rad    = sq_rad[0] + sq_rad[1] + sq_rad[2];
    assign data_next.tag      = up.tag;
    assign data_next.box_ok   = up.box_ok;
    assign data_next.kind     = up.kind;
    assign data_next.outer2   = up.outer2;
    assign data_next.inner_on = up.inner_on;
    assign data_next.inner2   = up.inner2;

    // stage handshake
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;
endmodule

`default_nettype wire

[rtl/prc_decide_stage.sv]
// prc_decide_stage: last pipeline stage, bound compares and output register
// depends on prc_pkg
`default_nettype none

module prc_decide_stage
    import prc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_ready,
    input  wire sum_t up,
    output logic      dn_valid,
    input  wire logic dn_ready,
    output result_t   dn
);
    logic    valid_reg;
    result_t data_reg;
    result_t data_next;
    logic    rad_in;
    logic    sph_in;
    logic    hole;

    // squared distance against squared bounds
    assign rad_in = up.d2rad <= SUM_W'(up.outer2);
    assign sph_in = up.d2all <= SUM_W'(up.outer2);
    assign hole   = up.inner_on && (up.d2rad < SUM_W'(up.inner2));

    // pick the test of the region kind
    always_comb
    begin
        data_next.tag = up.tag;
        unique case (up.kind)
            KIND_ALL:     data_next.in_region = 1'b1;
            KIND_BOX:     data_next.in_region = up.box_ok;
            KIND_CIRCLE:  data_next.in_region = rad_in;
            KIND_ANNULUS: data_next.in_region = rad_in && !hole;
            KIND_SPHERE:  data_next.in_region = sph_in;
            default:      data_next.in_region = 1'b0;
        endcase
    end

    // output register handshake
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;
endmodule

`default_nettype wire

[rtl/point_region_classifier_core.sv]
// point_region_classifier_core: four pipeline registers (difference, square, sum,
// decide); an accepted point passes through the four registers in that order and
// its result item is valid once the decide register holds it; throughput is one
// item per cycle, each stage holding under stall on its own so bubbles close up.
// Reset clears every stage valid bit and returns the registers to defaults (axis z).
// depends on prc_pkg, prc_point_if, prc_result_if and the four stage modules
`default_nettype none

module point_region_classifier_core
    import prc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    prc_point_if.sink                  point,
    prc_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    s1_valid;
    logic    s1_ready;
    diff_t   s1_data;
    logic    s2_valid;
    logic    s2_ready;
    square_t s2_data;
    logic    s3_valid;
    logic    s3_ready;
    sum_t    s3_data;
    result_t res_data;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REGION_KIND:     cfg_next.kind   = cfg_data[KIND_W-1:0];
                CFG_BOX_LOW_CORNER:  cfg_next.low    = cfg_data;
                CFG_BOX_HIGH_CORNER: cfg_next.high   = cfg_data;
                CFG_REGION_CENTER:   cfg_next.center = cfg_data;
                CFG_NORMAL_AXIS:     cfg_next.axis   = cfg_data[AXIS_W-1:0];
                CFG_OUTER_RADIUS:    cfg_next.outer  = cfg_data[RAD_W-1:0];
                CFG_INNER_RADIUS:    cfg_next.inner  = cfg_data[RAD_W-1:0];
                CFG_TOLERANCE:       cfg_next.tol    = cfg_data[RAD_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{kind: KIND_ALL, low: '0, high: '0, center: '0,
                         axis: AXIS_Z, outer: '0, inner: '0, tol: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // difference stage
    prc_diff_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_diff (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (point.valid),
        .up_ready (point.ready),
        .px       (point.point_x),
        .py       (point.point_y),
        .pz       (point.point_z),
        .ptag     (point.point_tag),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn       (s1_data)
    );

    // square stage
    prc_square_stage u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up       (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn       (s2_data)
    );

    // sum stage
    prc_sum_stage u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up       (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn       (s3_data)
    );

    // decide stage and output register
    prc_decide_stage u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .up       (s3_data),
        .dn_valid (result.valid),
        .dn_ready (result.ready),
        .dn       (res_data)
    );

    assign result.inside_res = res_data.in_region;
    assign result.result_tag = res_data.tag;
endmodule

`default_nettype wire

[test/region_check.sv]
`timescale 1ns / 100ps
// region_check: watches the point, result and register ports of the point region classifier,
// predicts the inside flag of every accepted point and compares it with the classified item
// depends on prc_pkg
module region_check
    import prc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          point_valid,
    input  logic                          point_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic [TAG_W-1:0]              point_tag,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic                          inside_res,
    input  logic [TAG_W-1:0]              result_tag,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            verdict_errors,
    output int                            outstanding
);

    localparam int MAX_REPORTS = 10;

    localparam cfg_t REGION_AT_RESET = '{kind: KIND_ALL, low: '0, high: '0, center: '0,
                                         axis: AXIS_Z, outer: '0, inner: '0, tol: '0};

    cfg_t    region;
    result_t pending_verdicts[$];
    result_t want;

    // signed coordinate idx of a packed x, y, z word
    function automatic longint coord_of(logic [CFG_DATA_W-1:0] word, int idx);
        logic signed [COORD_WIDTH-1:0] c;
        c = word[idx*COORD_WIDTH +: COORD_WIDTH];
        return c;
    endfunction

    // exact point-in-region test on squared distances
    function automatic logic point_in_region(cfg_t r, logic signed [COORD_WIDTH-1:0] px,
                                             logic signed [COORD_WIDTH-1:0] py,
                                             logic signed [COORD_WIDTH-1:0] pz);
        longint pt[3];
        longint sq[3];
        longint mag, tol, reach, reach2, hole, d2all, d2rad;
        logic   in_region;
        int     i;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        tol    = r.tol;
        reach  = r.outer;
        reach  = reach + tol;
        reach2 = reach * reach;
        // saturated squared component distances to the center
        for (i = 0; i < 3; i++)
        begin
            mag = pt[i] - coord_of(r.center, i);
            if (mag < 0)
                mag = -mag;
            if (mag > DIFF_CAP)
                mag = DIFF_CAP;
            sq[i] = mag * mag;
        end
        d2all = sq[0] + sq[1] + sq[2];
        // the normal axis drops out of the radial distance, an unused code drops nothing
        d2rad = (r.axis <= AXIS_Z) ? d2all - sq[r.axis] : d2all;
        case (r.kind)
            KIND_ALL:
                in_region = 1'b1;
            KIND_BOX:
            begin
                in_region = 1'b1;
                for (i = 0; i < 3; i++)
                begin
                    if (pt[i] < coord_of(r.low, i) - tol || pt[i] > coord_of(r.high, i) + tol)
                        in_region = 1'b0;
                end
            end
            KIND_CIRCLE:
                in_region = (d2rad <= reach2);
            KIND_ANNULUS:
            begin
                in_region = (d2rad <= reach2);
                // inner bound only bites while it stays above the tolerance
                if (r.inner > r.tol)
                begin
                    hole = r.inner;
                    hole = hole - tol;
                    if (d2rad < hole * hole)
                        in_region = 1'b0;
                end
            end
            KIND_SPHERE:
                in_region = (d2all <= reach2);
            default:
                in_region = 1'b0;
        endcase
        return in_region;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region <= REGION_AT_RESET;
            pending_verdicts.delete();
            verdict_errors = 0;
            outstanding   <= 0;
        end
        else
        begin
            // mirror register writes
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_REGION_KIND:     region.kind   <= cfg_data[KIND_W-1:0];
                    CFG_BOX_LOW_CORNER:  region.low    <= cfg_data;
                    CFG_BOX_HIGH_CORNER: region.high   <= cfg_data;
                    CFG_REGION_CENTER:   region.center <= cfg_data;
                    CFG_NORMAL_AXIS:     region.axis   <= cfg_data[AXIS_W-1:0];
                    CFG_OUTER_RADIUS:    region.outer  <= cfg_data[RAD_W-1:0];
                    CFG_INNER_RADIUS:    region.inner  <= cfg_data[RAD_W-1:0];
                    CFG_TOLERANCE:       region.tol    <= cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            // predict each accepted point item
            if (point_valid && point_ready)
                pending_verdicts.insert(pending_verdicts.size(), result_t'{
                    in_region: point_in_region(region, point_x, point_y, point_z),
                    tag:       point_tag});
            // compare each accepted result item with the oldest prediction
            if (result_valid && result_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    verdict_errors++;
                    if (verdict_errors <= MAX_REPORTS)
                        $display("%0t: unexpected result item: inside %0b tag %0d",
                                 $time, inside_res, result_tag);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (want.in_region !== inside_res || want.tag !== result_tag)
                    begin
                        verdict_errors++;
                        if (verdict_errors <= MAX_REPORTS)
                            $display("%0t: mismatch: inside exp %0b got %0b, tag exp %0d got %0d",
                                     $time, want.in_region, inside_res, want.tag, result_tag);
                    end
                end
            end
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// tb: drives points and region registers into point_region_classifier_core and gives the verdict
// depends on prc_pkg, prc_point_if, prc_result_if, the core and region_check
module tb;
    import prc_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int CMAX        = 2 ** (CW - 1) - 1;
    localparam int CMIN        = -(2 ** (CW - 1));
    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 104;
    localparam int HOLD_PHASE  = 8;
    localparam int PAUSE_PHASE = 5;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 16;
    localparam int STUCK_LIMIT = 2000;

    // codes the package leaves unnamed
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam logic [AXIS_W-1:0] AXIS_NONE      = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct;
    int stall_pct;
    bit hold_req;
    int stuck_cycles;
    int verdict_errors;
    int outstanding;

    prc_point_if #(.COORD_WIDTH(CW)) point_ch ();
    prc_result_if                    result_ch ();

    point_region_classifier_core #(.COORD_WIDTH(CW)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    region_check #(.COORD_WIDTH(CW)) i_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .point_valid    (point_ch.valid),
        .point_ready    (point_ch.ready),
        .point_x        (point_ch.point_x),
        .point_y        (point_ch.point_y),
        .point_z        (point_ch.point_z),
        .point_tag      (point_ch.point_tag),
        .result_valid   (result_ch.valid),
        .result_ready   (result_ch.ready),
        .inside_res     (result_ch.inside_res),
        .result_tag     (result_ch.result_tag),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .verdict_errors (verdict_errors),
        .outstanding    (outstanding)
    );

    // clock
    initial
        clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int clamp_coord(int v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack3(int x, int y, int z);
        return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    endfunction

    // region of random shape, kind chosen by phase
    function automatic cfg_t random_region(int phase);
        cfg_t r;
        int   i, lo, hi, span;
        case (phase % 6)
            0:       r.kind = KIND_ALL;
            1:       r.kind = KIND_BOX;
            2:       r.kind = KIND_CIRCLE;
            3:       r.kind = KIND_ANNULUS;
            4:       r.kind = KIND_SPHERE;
            default: r.kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
        endcase
        r.center = CFG_DATA_W'({$urandom(), $urandom()});
        // box corners, sometimes turned inside out
        for (i = 0; i < 3; i++)
        begin
            lo   = int'($urandom_range(CMAX - CMIN)) + CMIN;
            span = $urandom_range(3000);
            hi   = ($urandom_range(7) == 0) ? lo - span : lo + span;
            hi   = clamp_coord(hi);
            r.low[i*CW +: CW]  = lo[CW-1:0];
            r.high[i*CW +: CW] = hi[CW-1:0];
        end
        r.axis  = AXIS_W'($urandom_range(AXIS_NONE));
        r.outer = ($urandom_range(3) == 0) ? RAD_W'($urandom()) : RAD_W'($urandom_range(2000));
        r.inner = ($urandom_range(3) == 0) ? RAD_W'($urandom()) : RAD_W'($urandom_range(r.outer));
        r.tol   = ($urandom_range(7) == 0) ? RAD_W'($urandom()) : RAD_W'($urandom_range(100));
        return r;
    endfunction

    // point near the bounds of the region, now and then anywhere
    task automatic random_point(input cfg_t r, output logic signed [CW-1:0] px,
                                output logic signed [CW-1:0] py, output logic signed [CW-1:0] pz);
        int c[3];
        int i, lo, hi, a, b, reach;
        reach = r.outer + r.tol + 8;
        for (i = 0; i < 3; i++)
        begin
            lo = $signed(r.low[i*CW +: CW]) - int'(r.tol);
            hi = $signed(r.high[i*CW +: CW]) + int'(r.tol);
            a  = (lo < hi) ? lo : hi;
            b  = (lo < hi) ? hi : lo;
            if ($urandom_range(3) == 0)
                c[i] = int'($urandom_range(CMAX - CMIN)) + CMIN;
            else if (r.kind == KIND_BOX)
            begin
                case ($urandom_range(7))
                    0:       c[i] = lo;
                    1:       c[i] = lo - 1;
                    2:       c[i] = hi;
                    3:       c[i] = hi + 1;
                    default: c[i] = a - 8 + int'($urandom_range(b - a + 16));
                endcase
            end
            else
                c[i] = $signed(r.center[i*CW +: CW]) - reach + int'($urandom_range(2 * reach));
            c[i] = clamp_coord(c[i]);
        end
        px = c[0][CW-1:0];
        py = c[1][CW-1:0];
        pz = c[2][CW-1:0];
    endtask

    // offer one point item, with random idle cycles ahead of it
    task automatic send_point(input int px, input int py, input int pz, input int tag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid     <= 1'b1;
        point_ch.point_x   <= px[CW-1:0];
        point_ch.point_y   <= py[CW-1:0];
        point_ch.point_z   <= pz[CW-1:0];
        point_ch.point_tag <= tag[TAG_W-1:0];
        do @(posedge clk); while (!point_ch.ready);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // load a whole region once the pipeline has emptied
    task automatic program_region(input cfg_t r);
        point_ch.valid <= 1'b0;
        wait_drained();
        write_reg(CFG_REGION_KIND, CFG_DATA_W'(r.kind));
        write_reg(CFG_BOX_LOW_CORNER, r.low);
        write_reg(CFG_BOX_HIGH_CORNER, r.high);
        write_reg(CFG_REGION_CENTER, r.center);
        write_reg(CFG_NORMAL_AXIS, CFG_DATA_W'(r.axis));
        write_reg(CFG_OUTER_RADIUS, CFG_DATA_W'(r.outer));
        write_reg(CFG_INNER_RADIUS, CFG_DATA_W'(r.inner));
        write_reg(CFG_TOLERANCE, CFG_DATA_W'(r.tol));
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls, or one long hold-off on request
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // stimulus
    initial
    begin
        cfg_t                  region;
        logic signed [CW-1:0]  px, py, pz;
        int                    phase, n;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_REGION_KIND;
        cfg_data           = '0;
        point_ch.valid     = 1'b0;
        point_ch.point_x   = '0;
        point_ch.point_y   = '0;
        point_ch.point_z   = '0;
        point_ch.point_tag = '0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        hold_req           = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: every point is inside
        send_point(CMIN, CMIN, CMIN, 0);
        send_point(CMAX, CMAX, CMAX, 'hFFFF);
        send_point(0, -1, 1, 'h5A5A);

        // box faces widened by the tolerance, just on and just off
        program_region(cfg_t'{KIND_BOX, pack3(-100, -200, -300), pack3(100, 200, 300),
                              48'd0, AXIS_Z, 16'd0, 16'd0, 16'd5});
        send_point(-105, 0, 0, 1);
        send_point(-106, 0, 0, 2);
        send_point(105, 205, 305, 3);
        send_point(106, 0, 0, 4);
        send_point(0, 206, 0, 5);

        // inverted box: empty until twice the tolerance covers the overlap
        program_region(cfg_t'{KIND_BOX, pack3(50, 50, 50), pack3(0, 0, 0),
                              48'd0, AXIS_Z, 16'd0, 16'd0, 16'd20});
        send_point(25, 25, 25, 6);
        program_region(cfg_t'{KIND_BOX, pack3(50, 50, 50), pack3(0, 0, 0),
                              48'd0, AXIS_Z, 16'd0, 16'd0, 16'd30});
        send_point(25, 25, 25, 7);

        // circle about z on its rim, then with no axis left out
        program_region(cfg_t'{KIND_CIRCLE, 48'd0, 48'd0, pack3(10, 20, 30),
                              AXIS_Z, 16'd100, 16'd0, 16'd10});
        send_point(120, 20, CMIN, 8);
        send_point(121, 20, CMIN, 9);
        program_region(cfg_t'{KIND_CIRCLE, 48'd0, 48'd0, pack3(10, 20, 30),
                              AXIS_NONE, 16'd100, 16'd0, 16'd10});
        send_point(120, 20, CMIN, 10);

        // annulus about x: inner and outer rims
        program_region(cfg_t'{KIND_ANNULUS, 48'd0, 48'd0, 48'd0,
                              AXIS_X, 16'd200, 16'd100, 16'd10});
        send_point(CMAX, 89, 0, 11);
        send_point(CMAX, 90, 0, 12);
        send_point(0, 211, 0, 13);
        // inner radius below the tolerance: no hole at all
        program_region(cfg_t'{KIND_ANNULUS, 48'd0, 48'd0, 48'd0,
                              AXIS_X, 16'd200, 16'd5, 16'd10});
        send_point(0, 0, 0, 14);

        // sphere at the widest reach, then of zero size
        program_region(cfg_t'{KIND_SPHERE, 48'd0, 48'd0, pack3(CMIN, CMAX, 0),
                              AXIS_Z, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_point(CMAX, CMIN, 0, 15);
        program_region(cfg_t'{KIND_SPHERE, 48'd0, 48'd0, pack3(1, 2, 3),
                              AXIS_Y, 16'd0, 16'd0, 16'd0});
        send_point(1, 2, 3, 16);
        send_point(1, 2, 4, 17);

        // unused kinds hold nothing
        program_region(cfg_t'{KIND_UNUSED_LO, 48'd0, 48'd0, 48'd0,
                              AXIS_Z, 16'd0, 16'd0, 16'd0});
        send_point(0, 0, 0, 18);
        program_region(cfg_t'{KIND_UNUSED_HI, 48'd0, 48'd0, 48'd0,
                              AXIS_Z, 16'd0, 16'd0, 16'd0});
        send_point(0, 0, 0, 19);

        // random regions and points, idling pattern cycling per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            region = random_region(phase);
            if (phase == 3)
            begin
                region.outer = 16'hFFFF;
                region.inner = 16'hFFFF;
                region.tol   = 16'd0;
            end
            else if (phase == 4)
            begin
                region.outer = 16'hFFFF;
                region.tol   = 16'hFFFF;
            end
            else if (phase == 7)
            begin
                region.low  = pack3(CMIN, CMIN, CMIN);
                region.high = pack3(CMAX, CMAX, CMAX);
                region.tol  = 16'd0;
            end
            else if (phase == 8)
            begin
                region.outer = 16'd0;
                region.tol   = 16'd0;
            end
            program_region(region);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 76; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long result hold-off while points keep coming
                if (phase == HOLD_PHASE && n == 0)
                    hold_req = 1'b1;
                // sender pause until every result is back
                if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2)
                begin
                    point_ch.valid <= 1'b0;
                    wait_drained();
                end
                random_point(region, px, py, pz);
                send_point(int'(px), int'(py), int'(pz), int'($urandom_range('hFFFF)));
            end
        end

        // drain and verdict
        point_ch.valid <= 1'b0;
        stall_pct = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (verdict_errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/prc_pkg.sv
rtl/prc_point_if.sv
rtl/prc_result_if.sv
rtl/prc_diff_stage.sv
rtl/prc_square_stage.sv
rtl/prc_sum_stage.sv
rtl/prc_decide_stage.sv
rtl/point_region_classifier_core.sv
test/region_check.sv
test/tb.sv
